[rtl/isotp_pkg.sv]
// Shared types, constants and byte helpers for the ISO-TP receive reassembler.
// No dependencies; imported by the top level and the message store.
`default_nettype none

package isotp_pkg;

  localparam int unsigned ID_W     = 29;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned WIDX_W   = 9;
  localparam int unsigned WORD_W   = 64;

  localparam logic [3:0] PCI_SINGLE      = 4'h0;
  localparam logic [3:0] PCI_FIRST       = 4'h1;
  localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_RD    = 7'b0000100,
    S_MRG0  = 7'b0001000,
    S_MRG1  = 7'b0010000,
    S_ORD   = 7'b0100000,
    S_OWAIT = 7'b1000000
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [WIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [WIDX_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } mem_req_t;

  // top n bytes set, n clipped at 8
  function automatic logic [WORD_W-1:0] byte_mask(input logic [3:0] n);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < n) m[WORD_W-1-8*j -: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [WORD_W-1:0] keep_bytes(input logic [WORD_W-1:0] w,
                                                   input logic [3:0] n);
    return w & byte_mask(n);
  endfunction

endpackage

`default_nettype wire

[rtl/isotp_store.sv]
// Message store: one synchronous write port, one registered read port.
// Depends on isotp_pkg for the request struct.
`default_nettype none

module isotp_store #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire isotp_pkg::mem_req_t      req,
  output      logic [isotp_pkg::WORD_W-1:0] rd_data
);
  import isotp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr[AW-1:0]] <= req.wr_data;
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) rd_data <= mem[req.rd_addr[AW-1:0]];
  end

endmodule

`default_nettype wire

[rtl/isotp_receive_reassembler_unit.sv]
// ISO-TP receive reassembler, top level: frame decode, reception control, readout.
// Depends on isotp_pkg and isotp_store.
//
// Usage:
//   Frame channel (frame_valid/frame_stall, frame_id, frame_bytes, frame_payload)
//   takes one classic CAN frame per transaction. Word channel (word_valid/
//   word_stall, sender_id, message_word, word_bytes, last_word) gives message
//   words, last_word on the final one of each message.
//   A frame that stores nothing passes S_IDLE and S_DEC; one whose bytes sit
//   in one store word adds S_RD and S_MRG0, and S_MRG1 when they span two
//   (read-merge-write on the store). A single frame result is loaded into
//   the word register from S_DEC, which waits while the register is held. A
//   completed message is read out one word per S_ORD/S_OWAIT pass, one store
//   read each, and holds the frame channel until its last word is loaded.
//   The word register lets the next frame be taken while a result still waits;
//   while the receiver stalls and a new result is due, the block holds in place
//   and stalls the frame channel.
//   Reset (rst, synchronous) returns control to idle with no reception open and
//   the word register empty; the frame channel stalls while rst is high. Store
//   contents are not cleared; only bytes of the current reception are ever read out.
`default_nettype none

module isotp_receive_reassembler_unit #(
  parameter int unsigned MAX_MESSAGE_BYTES = 512
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         frame_valid,
  output      logic                         frame_stall,
  input  wire logic [isotp_pkg::ID_W-1:0]   frame_id,
  input  wire logic [3:0]                   frame_bytes,
  input  wire logic [isotp_pkg::WORD_W-1:0] frame_payload,
  output      logic                         word_valid,
  input  wire logic                         word_stall,
  output      logic [isotp_pkg::ID_W-1:0]   sender_id,
  output      logic [isotp_pkg::WORD_W-1:0] message_word,
  output      logic [3:0]                   word_bytes,
  output      logic                         last_word
);
  import isotp_pkg::*;

  localparam int unsigned STORE_WORDS = (MAX_MESSAGE_BYTES + 7) / 8;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MESSAGE_BYTES);

  state_t state, state_next;

  // latched frame
  logic [ID_W-1:0]   f_id;
  logic [3:0]        f_size;
  logic [WORD_W-1:0] f_data;

  // reception state
  logic              receiving, receiving_next;
  logic [ID_W-1:0]   active_sender, active_sender_next;
  logic [LEN_W-1:0]  total_length, total_length_next;
  logic [LEN_W-1:0]  bytes_received, bytes_received_next;
  logic [3:0]        next_sequence, next_sequence_next;
  logic              msg_done, msg_done_next;

  // pending store write
  logic [LEN_W-1:0]  wr_pos, wr_pos_next;
  logic [2:0]        wr_cnt, wr_cnt_next;
  logic [WORD_W-1:0] wr_bytes, wr_bytes_next;

  logic [WIDX_W-1:0] out_idx, out_idx_next;

  mem_req_t          req;
  logic [WORD_W-1:0] rd_data;

  isotp_store #(
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // decode
  logic [3:0]       pci, low;
  logic [LEN_W-1:0] ff_len, remaining, rx_new;
  logic [3:0]       ff_avail, cf_avail, ff_init, cf_copy, sf_n;
  logic             out_free;

  assign pci      = f_data[63:60];
  assign low      = f_data[59:56];
  assign ff_len   = {low, f_data[55:48]};
  assign ff_avail = 4'(f_size - 4'd2);
  assign cf_avail = 4'(f_size - 4'd1);
  assign ff_init  = (ff_len < LEN_W'(ff_avail)) ? ff_len[3:0] : ff_avail;
  assign remaining = (total_length > bytes_received) ? LEN_W'(total_length - bytes_received)
                                                      : '0;
  assign cf_copy  = (remaining < LEN_W'(cf_avail)) ? remaining[3:0] : cf_avail;
  assign rx_new   = LEN_W'(bytes_received + LEN_W'(cf_copy));
  assign sf_n     = (low < cf_avail) ? low : cf_avail;
  assign out_free = !word_valid || !word_stall;

  // byte-aligned merge of pending bytes into two adjacent store words
  logic [2*WORD_W-1:0] dat_sh, msk_sh;
  logic [WIDX_W-1:0]   base_idx;
  logic [WORD_W-1:0]   merge_lo_mask;

  assign dat_sh        = {wr_bytes, {WORD_W{1'b0}}} >> {wr_pos[2:0], 3'b000};
  assign msk_sh        = {byte_mask({1'b0, wr_cnt}), {WORD_W{1'b0}}} >> {wr_pos[2:0], 3'b000};
  assign base_idx      = wr_pos[LEN_W-1:3];
  assign merge_lo_mask = msk_sh[WORD_W-1:0];

  // readout
  logic [LEN_W-1:0] out_rem;
  logic [3:0]       out_n;
  logic             out_last;

  assign out_rem  = LEN_W'(total_length - {out_idx, 3'b000});
  assign out_n    = (out_rem > LEN_W'(8)) ? 4'd8 : out_rem[3:0];
  assign out_last = (out_rem <= LEN_W'(8));

  always_comb begin
    req         = '0;
    req.rd_addr = base_idx;
    req.wr_addr = base_idx;
    case (state)
      S_RD: begin
        req.rd_en = 1'b1;
      end
      S_MRG0: begin
        req.rd_en   = (merge_lo_mask != '0);
        req.rd_addr = WIDX_W'(base_idx + 1'b1);
        req.wr_en   = 1'b1;
        req.wr_data = (rd_data & ~msk_sh[2*WORD_W-1:WORD_W])
                    | (dat_sh[2*WORD_W-1:WORD_W] & msk_sh[2*WORD_W-1:WORD_W]);
      end
      S_MRG1: begin
        req.wr_en   = 1'b1;
        req.wr_addr = WIDX_W'(base_idx + 1'b1);
        req.wr_data = (rd_data & ~merge_lo_mask) | (dat_sh[WORD_W-1:0] & merge_lo_mask);
      end
      S_ORD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = out_idx;
      end
      default: ;
    endcase
  end

  // output register load
  logic              load;
  logic [ID_W-1:0]   load_id;
  logic [WORD_W-1:0] load_word;
  logic [3:0]        load_n;
  logic              load_last;

  always_comb begin
    state_next          = state;
    receiving_next      = receiving;
    active_sender_next  = active_sender;
    total_length_next   = total_length;
    bytes_received_next = bytes_received;
    next_sequence_next  = next_sequence;
    msg_done_next       = msg_done;
    wr_pos_next         = wr_pos;
    wr_cnt_next         = wr_cnt;
    wr_bytes_next       = wr_bytes;
    out_idx_next        = out_idx;
    load                = 1'b0;
    load_id             = active_sender;
    load_word           = keep_bytes(rd_data, out_n);
    load_n              = out_n;
    load_last           = out_last;

    case (state)
      S_IDLE: begin
        if (frame_valid) state_next = S_DEC;
      end
      S_DEC: begin
        state_next = S_IDLE;
        if (f_size == 4'd0) begin
          state_next = S_IDLE;
        end else if (pci == PCI_SINGLE) begin
          load_id   = f_id;
          load_word = keep_bytes(f_data << 8, sf_n);
          load_n    = sf_n;
          load_last = 1'b1;
          if (out_free) load = 1'b1;
          else state_next = S_DEC;
        end else if (pci == PCI_FIRST) begin
          if (f_size >= 4'd2 && ff_len <= MAX_LEN) begin
            total_length_next   = ff_len;
            bytes_received_next = LEN_W'(ff_init);
            next_sequence_next  = 4'd1;
            active_sender_next  = f_id;
            receiving_next      = 1'b1;
            msg_done_next       = 1'b0;
            wr_pos_next         = '0;
            wr_cnt_next         = ff_init[2:0];
            wr_bytes_next       = f_data << 16;
            if (ff_init != 4'd0) state_next = S_RD;
          end
        end else if (pci == PCI_CONSECUTIVE) begin
          if (receiving && f_id == active_sender) begin
            if (low != next_sequence) begin
              receiving_next = 1'b0;
            end else begin
              next_sequence_next  = 4'(low + 4'd1);
              bytes_received_next = rx_new;
              wr_pos_next         = bytes_received;
              wr_cnt_next         = cf_copy[2:0];
              wr_bytes_next       = f_data << 8;
              msg_done_next       = (rx_new >= total_length);
              if (rx_new >= total_length) receiving_next = 1'b0;
              out_idx_next = '0;
              if (cf_copy != 4'd0) state_next = S_RD;
              else if (rx_new >= total_length) state_next = S_ORD;
            end
          end
        end
      end
      S_RD: begin
        state_next = S_MRG0;
      end
      S_MRG0: begin
        if (merge_lo_mask != '0) state_next = S_MRG1;
        else state_next = msg_done ? S_ORD : S_IDLE;
      end
      S_MRG1: begin
        state_next = msg_done ? S_ORD : S_IDLE;
      end
      S_ORD: begin
        state_next = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_free) begin
          load = 1'b1;
          if (out_last) begin
            state_next    = S_IDLE;
            msg_done_next = 1'b0;
          end else begin
            out_idx_next = WIDX_W'(out_idx + 1'b1);
            state_next   = S_ORD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign frame_stall = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      receiving      <= 1'b0;
      active_sender  <= '0;
      total_length   <= '0;
      bytes_received <= '0;
      next_sequence  <= 4'd1;
      msg_done       <= 1'b0;
      out_idx        <= '0;
      word_valid     <= 1'b0;
    end else begin
      state          <= state_next;
      receiving      <= receiving_next;
      active_sender  <= active_sender_next;
      total_length   <= total_length_next;
      bytes_received <= bytes_received_next;
      next_sequence  <= next_sequence_next;
      msg_done       <= msg_done_next;
      out_idx        <= out_idx_next;
      if (load) word_valid <= 1'b1;
      else if (!word_stall) word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && frame_valid) begin
      f_id   <= frame_id;
      f_size <= (frame_bytes > 4'd8) ? 4'd8 : frame_bytes;
      f_data <= frame_payload;
    end
    wr_pos   <= wr_pos_next;
    wr_cnt   <= wr_cnt_next;
    wr_bytes <= wr_bytes_next;
    if (load) begin
      sender_id    <= load_id;
      message_word <= load_word;
      word_bytes   <= load_n;
      last_word    <= load_last;
    end
  end

endmodule

`default_nettype wire

[rtl/isotp_rx_chk.sv]
// Port-level checker for the ISO-TP receive reassembler, bound to the top level.
// No package dependency.
`default_nettype none

module isotp_rx_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        frame_valid,
  input wire logic        frame_stall,
  input wire logic        word_valid,
  input wire logic        word_stall,
  input wire logic [63:0] message_word,
  input wire logic [3:0]  word_bytes,
  input wire logic        last_word
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !word_valid)
    else $error("word register not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_stall |=> word_valid && $stable(message_word) && $stable(word_bytes))
    else $error("stalled word changed");

  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    word_valid |-> word_bytes <= 4'd8)
    else $error("word byte count above eight");

  a_full_mid: assert property (@(posedge clk) disable iff (rst)
    word_valid && !last_word |-> word_bytes == 4'd8)
    else $error("non-final word not full");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_stall |=> frame_stall)
    else $error("frame taken without decode cycle");

endmodule

bind isotp_receive_reassembler_unit isotp_rx_chk u_isotp_rx_chk (.*);

`default_nettype wire
